>>> rtl/lsb_pkg.sv
// Shared types and constants for the layered sprite list buffer.
// Used by lsb_ctrl, lsb_dp and the top level; depends on nothing.
package lsb_pkg;

  // Sizing
  localparam int SPRITE_SLOTS = 128;
  localparam int MATRIX_SLOTS = 32;
  localparam int LAYERS       = 4;

  localparam int NODE_W  = 8;
  localparam int CNT_W   = 8;
  localparam int SPR_AW  = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
  localparam int MAT_AW  = (MATRIX_SLOTS > 1) ? $clog2(MATRIX_SLOTS) : 1;
  localparam int MCNT_W  = $clog2(MATRIX_SLOTS + 1);
  localparam int SPR_W   = NODE_W + 48;
  localparam int MAT_W   = 64;

  localparam logic [NODE_W-1:0] NIL        = 8'hFF;
  localparam logic [2:0]        LAST_LAYER = 3'(LAYERS - 1);

  // Command codes of an input item
  typedef enum logic [2:0] {
    CMD_CLEAR       = 3'd0,
    CMD_ADD         = 3'd1,
    CMD_ADD_AFFINE  = 3'd2,
    CMD_NEXT_SPRITE = 3'd3,
    CMD_NEXT_MATRIX = 3'd4
  } cmd_e;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ADD,
    OP_ADD_AFFINE,
    OP_ZERO,
    OP_MAT_READ,
    OP_MAT_EMIT,
    OP_MAT_EMPTY,
    OP_SCAN_TAKE_NODE,
    OP_SCAN_TAKE_TAIL,
    OP_SCAN_DOWN,
    OP_SCAN_EMPTY,
    OP_SPR_EMIT
  } dp_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SREAD,
    ST_MREAD
  } state_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [2:0]         layer;
    logic [15:0]        attr_word0;
    logic [15:0]        attr_word1;
    logic [15:0]        attr_word2;
    logic signed [15:0] mat_a;
    logic signed [15:0] mat_b;
    logic signed [15:0] mat_c;
    logic signed [15:0] mat_d;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [4:0]         affine_slot;
    logic               present;
    logic [15:0]        out_attr0;
    logic [15:0]        out_attr1;
    logic [15:0]        out_attr2;
    logic signed [15:0] out_a;
    logic signed [15:0] out_b;
    logic signed [15:0] out_c;
    logic signed [15:0] out_d;
    logic               last_of_pass;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_e op;
    logic   capture;
    logic   publish;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       add_ok;
    logic       affine_ok;
    logic       node_ok;
    logic       tail_ok;
    logic       layer_zero;
    logic       mat_avail;
    logic       res_pend;
    logic       out_free;
  } status_t;

endpackage

>>> rtl/lsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

>>> rtl/lsb_ctrl.sv
// Controller state machine of the layered sprite list buffer.
// Depends on lsb_pkg; drives datapath operations from datapath status.
module lsb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lsb_pkg::status_t status_i,
  output lsb_pkg::ctl_t    ctl_o
);
  import lsb_pkg::*;

  state_e state_q, state_d;
  dp_op_e scan_op;
  state_e scan_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // One step of the layer walk: current node, else layer head, else go down, or end the pass at layer 0
  always_comb begin
    priority if (status_i.node_ok) begin
      scan_op   = OP_SCAN_TAKE_NODE;
      scan_next = ST_SREAD;
    end else if (status_i.tail_ok) begin
      scan_op   = OP_SCAN_TAKE_TAIL;
      scan_next = ST_SREAD;
    end else if (status_i.layer_zero) begin
      scan_op   = OP_SCAN_EMPTY;
      scan_next = ST_IDLE;
    end else begin
      scan_op   = OP_SCAN_DOWN;
      scan_next = ST_SCAN;
    end
  end

  // Next state and operations
  always_comb begin
    state_d       = state_q;
    in_stall_o    = !((state_q == ST_IDLE) && (!status_i.res_pend || status_i.out_free));
    ctl_o.op      = OP_NONE;
    ctl_o.publish = status_i.res_pend && status_i.out_free;
    ctl_o.capture = in_valid_i && !in_stall_o;

    unique case (state_q)
      ST_IDLE: begin
        if (ctl_o.capture) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status_i.cmd)
          CMD_CLEAR: begin
            ctl_o.op = OP_CLEAR;
            state_d  = ST_IDLE;
          end
          CMD_ADD: begin
            ctl_o.op = status_i.add_ok ? OP_ADD : OP_ZERO;
            state_d  = ST_IDLE;
          end
          CMD_ADD_AFFINE: begin
            ctl_o.op = status_i.affine_ok ? OP_ADD_AFFINE : OP_ZERO;
            state_d  = ST_IDLE;
          end
          CMD_NEXT_SPRITE: begin
            ctl_o.op = scan_op;
            state_d  = scan_next;
          end
          CMD_NEXT_MATRIX: begin
            if (status_i.mat_avail) begin
              ctl_o.op = OP_MAT_READ;
              state_d  = ST_MREAD;
            end else begin
              ctl_o.op = OP_MAT_EMPTY;
              state_d  = ST_IDLE;
            end
          end
          default: begin
            // unused command codes give an all-zero result
            ctl_o.op = OP_ZERO;
            state_d  = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        ctl_o.op = scan_op;
        state_d  = scan_next;
      end
      ST_SREAD: begin
        ctl_o.op = OP_SPR_EMIT;
        state_d  = ST_IDLE;
      end
      ST_MREAD: begin
        ctl_o.op = OP_MAT_EMIT;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/lsb_dp.sv
// Datapath of the layered sprite list buffer: layer heads, counters,
// cursors, sprite and matrix RAMs, result staging and output register.
// Depends on lsb_pkg and lsb_ram.
module lsb_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsb_pkg::in_item_t  in_item_i,
  input  lsb_pkg::ctl_t      ctl_i,
  output lsb_pkg::status_t   status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lsb_pkg::out_item_t out_item_o
);
  import lsb_pkg::*;

  function automatic logic node_ok(input logic [NODE_W-1:0] n, input logic [CNT_W-1:0] cnt);
    return (n != NIL) && (n < cnt);
  endfunction

  // Control state
  logic [NODE_W-1:0] tail_q [LAYERS];
  logic [NODE_W-1:0] tail_d [LAYERS];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [MCNT_W-1:0] mcnt_q, mcnt_d;
  logic [MCNT_W-1:0] mcur_q, mcur_d;
  logic [MCNT_W-1:0] mcur_inc;
  logic [2:0]        cur_layer_q, cur_layer_d;
  logic [NODE_W-1:0] cur_node_q, cur_node_d;
  logic              res_pend_q, res_pend_d;
  logic              out_valid_q;

  // Payload
  in_item_t  req_q;
  out_item_t res_q, res_d;
  out_item_t out_q;
  logic      res_wr;

  // Lookups
  logic [NODE_W-1:0] tail_req, tail_cur, link;
  logic [LAYERS-1:0] tail_ok_vec;
  logic              below_any, layer_ok, link_ok;
  logic [4:0]        slot;
  logic [15:0]       a1_aff;

  // RAM ports
  logic              spr_wr_en, spr_rd_en, mat_wr_en, mat_rd_en;
  logic [SPR_AW-1:0] spr_rd_addr;
  logic [SPR_W-1:0]  spr_wr_data, spr_rd_data;
  logic [MAT_W-1:0]  mat_rd_data;

  lsb_ram #(.WIDTH(SPR_W), .DEPTH(SPRITE_SLOTS)) u_spr_ram (
    .clk_i     (clk_i),
    .wr_en_i   (spr_wr_en),
    .wr_addr_i (cnt_q[SPR_AW-1:0]),
    .wr_data_i (spr_wr_data),
    .rd_en_i   (spr_rd_en),
    .rd_addr_i (spr_rd_addr),
    .rd_data_o (spr_rd_data)
  );

  lsb_ram #(.WIDTH(MAT_W), .DEPTH(MATRIX_SLOTS)) u_mat_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mat_wr_en),
    .wr_addr_i (mcnt_q[MAT_AW-1:0]),
    .wr_data_i ({req_q.mat_a, req_q.mat_b, req_q.mat_c, req_q.mat_d}),
    .rd_en_i   (mat_rd_en),
    .rd_addr_i (mcur_q[MAT_AW-1:0]),
    .rd_data_o (mat_rd_data)
  );

  // Layer head selection and walk lookahead
  always_comb begin
    tail_req  = NIL;
    tail_cur  = NIL;
    below_any = 1'b0;
    for (int l = 0; l < LAYERS; l++) begin
      tail_ok_vec[l] = node_ok(tail_q[l], cnt_q);
      if (3'(l) == req_q.layer) tail_req = tail_q[l];
      if (3'(l) == cur_layer_q) tail_cur = tail_q[l];
      if ((3'(l) < cur_layer_q) && tail_ok_vec[l]) below_any = 1'b1;
    end
  end

  assign layer_ok = ({5'd0, req_q.layer} < 8'(LAYERS));
  assign link     = spr_rd_data[SPR_W-1 -: NODE_W];
  assign link_ok  = node_ok(link, cnt_q);
  assign slot     = 5'(mcnt_q);
  assign a1_aff   = {req_q.attr_word1[15:14], slot, req_q.attr_word1[8:0]};
  assign mcur_inc = mcur_q + MCNT_W'(1);

  // Status to the controller
  always_comb begin
    status_o.cmd        = req_q.command;
    status_o.add_ok     = (cnt_q < CNT_W'(SPRITE_SLOTS)) && layer_ok;
    status_o.affine_ok  = status_o.add_ok && (mcnt_q < MCNT_W'(MATRIX_SLOTS));
    status_o.node_ok    = node_ok(cur_node_q, cnt_q);
    status_o.tail_ok    = node_ok(tail_cur, cnt_q);
    status_o.layer_zero = (cur_layer_q == 3'd0);
    status_o.mat_avail  = (mcur_q < mcnt_q);
    status_o.res_pend   = res_pend_q;
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Operation execution
  always_comb begin
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    mcnt_d      = mcnt_q;
    mcur_d      = mcur_q;
    cur_layer_d = cur_layer_q;
    cur_node_d  = cur_node_q;
    res_d       = '0;
    res_wr      = 1'b0;
    spr_wr_en   = 1'b0;
    mat_wr_en   = 1'b0;
    spr_rd_en   = 1'b0;
    mat_rd_en   = 1'b0;
    spr_rd_addr = cur_node_q[SPR_AW-1:0];
    spr_wr_data = {tail_req, req_q.attr_word0,
                   (ctl_i.op == OP_ADD_AFFINE) ? a1_aff : req_q.attr_word1,
                   req_q.attr_word2};

    unique case (ctl_i.op)
      OP_NONE: begin
      end
      OP_CLEAR: begin
        for (int l = 0; l < LAYERS; l++) tail_d[l] = NIL;
        cnt_d          = '0;
        mcnt_d         = '0;
        mcur_d         = '0;
        cur_layer_d    = LAST_LAYER;
        cur_node_d     = NIL;
        res_wr         = 1'b1;
        res_d.accepted = 1'b1;
      end
      OP_ADD, OP_ADD_AFFINE: begin
        spr_wr_en = 1'b1;
        for (int l = 0; l < LAYERS; l++) begin
          if (3'(l) == req_q.layer) tail_d[l] = cnt_q;
        end
        cnt_d          = cnt_q + CNT_W'(1);
        res_wr         = 1'b1;
        res_d.accepted = 1'b1;
        if (ctl_i.op == OP_ADD_AFFINE) begin
          mat_wr_en         = 1'b1;
          mcnt_d            = mcnt_q + MCNT_W'(1);
          res_d.affine_slot = slot;
        end
      end
      OP_ZERO: begin
        res_wr = 1'b1;
      end
      OP_MAT_READ: begin
        mat_rd_en = 1'b1;
      end
      OP_MAT_EMIT: begin
        res_wr        = 1'b1;
        res_d.present = 1'b1;
        res_d.out_a   = signed'(mat_rd_data[63:48]);
        res_d.out_b   = signed'(mat_rd_data[47:32]);
        res_d.out_c   = signed'(mat_rd_data[31:16]);
        res_d.out_d   = signed'(mat_rd_data[15:0]);
        if (mcur_inc >= mcnt_q) begin
          res_d.last_of_pass = 1'b1;
          mcur_d             = '0;
        end else begin
          mcur_d = mcur_inc;
        end
      end
      OP_MAT_EMPTY: begin
        res_wr             = 1'b1;
        res_d.last_of_pass = 1'b1;
        mcur_d             = '0;
      end
      OP_SCAN_TAKE_NODE: begin
        spr_rd_en = 1'b1;
      end
      OP_SCAN_TAKE_TAIL: begin
        spr_rd_en   = 1'b1;
        spr_rd_addr = tail_cur[SPR_AW-1:0];
        cur_node_d  = tail_cur;
      end
      OP_SCAN_DOWN: begin
        cur_node_d  = NIL;
        cur_layer_d = cur_layer_q - 3'd1;
      end
      OP_SCAN_EMPTY: begin
        res_wr             = 1'b1;
        res_d.last_of_pass = 1'b1;
        cur_layer_d        = LAST_LAYER;
        cur_node_d         = NIL;
      end
      OP_SPR_EMIT: begin
        res_wr          = 1'b1;
        res_d.present   = 1'b1;
        res_d.out_attr0 = spr_rd_data[47:32];
        res_d.out_attr1 = spr_rd_data[31:16];
        res_d.out_attr2 = spr_rd_data[15:0];
        // follow the link, else the pass is over at layer 0 or with no lower head, else drop a layer
        priority if (link_ok) begin
          cur_node_d = link;
        end else if ((cur_layer_q == 3'd0) || !below_any) begin
          res_d.last_of_pass = 1'b1;
          cur_layer_d        = LAST_LAYER;
          cur_node_d         = NIL;
        end else begin
          cur_node_d  = NIL;
          cur_layer_d = cur_layer_q - 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result staging flag
  always_comb begin
    res_pend_d = res_pend_q;
    if (ctl_i.publish) res_pend_d = 1'b0;
    if (res_wr)        res_pend_d = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LAYERS; l++) tail_q[l] <= NIL;
      cnt_q       <= '0;
      mcnt_q      <= '0;
      mcur_q      <= '0;
      cur_layer_q <= LAST_LAYER;
      cur_node_q  <= NIL;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      mcnt_q      <= mcnt_d;
      mcur_q      <= mcur_d;
      cur_layer_q <= cur_layer_d;
      cur_node_q  <= cur_node_d;
      res_pend_q  <= res_pend_d;
      if (ctl_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) req_q <= in_item_i;
    if (res_wr)        res_q <= res_d;
    if (ctl_i.publish) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_cursor_layer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_layer_q} < 4'(LAYERS)))
    else $error("sprite cursor layer out of range");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CNT_W'(SPRITE_SLOTS)) && (mcnt_q <= MCNT_W'(MATRIX_SLOTS)))
    else $error("store count beyond capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr |-> !res_pend_q)
    else $error("result staged over an unpublished one");

  a_emit_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_SPR_EMIT) |->
      ($past(ctl_i.op) == OP_SCAN_TAKE_NODE || $past(ctl_i.op) == OP_SCAN_TAKE_TAIL))
    else $error("sprite emitted without a preceding read");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.publish |-> (res_pend_q && (!out_valid_q || !out_stall_i)))
    else $error("publish into a busy output register");

endmodule

>>> rtl/layered_sprite_list_buffer.sv
// Layered sprite list buffer: one command item in, one result item out.
// Top level; depends on lsb_pkg, lsb_ctrl, lsb_dp (and lsb_ram below it).
//
// Input channel: in_valid_i / in_stall_o / in_item_i carry command items
// (clear, add sprite, add affine sprite, next sprite, next matrix). Output
// channel: out_valid_o / out_stall_i / out_item_o carry exactly one result
// item per command. An item moves when valid is high and stall is low.
// Commands run one at a time. Clear, add and unused codes are captured
// and then executed; a matrix read issues a registered matrix RAM read
// and then emits its data, or an end-of-pass result when no matrix is
// left; a sprite read steps down over each empty layer it meets, at most
// LAYERS-1 of them, then reads the sprite RAM and emits, or gives an
// end-of-pass result when it finds no sprite left. The walk checks one
// layer head per cycle and the sprite RAM read is registered.
// A finished result waits in a staging register; the next command is
// taken as soon as the output register can receive that staged result,
// so a stalled receiver holds at most one result item plus one staged.
// Reset empties all layers, counters and cursors at once; RAM contents
// are left as they are and are never read before being written.
module layered_sprite_list_buffer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lsb_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lsb_pkg::out_item_t out_item_o
);
  import lsb_pkg::*;

  ctl_t    ctl;
  status_t status;

  lsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctl_o      (ctl)
  );

  lsb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .ctl_i       (ctl),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
